>>> hw/rtl/pgtl_pkg.sv
// Shared types and constants for the probe grid trilinear lookup.
package pgtl_pkg;

    localparam int COUNT_BITS = 8;
    localparam int FRAC_BITS  = 16;
    localparam int POS_W      = 32;
    localparam int IDX_W      = 24;
    localparam int WEIGHT_W   = FRAC_BITS + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int DIFF_W     = POS_W + 2;
    localparam int UD_W       = POS_W + 1;
    localparam int QUO_W      = UD_W + FRAC_BITS;
    localparam int STEP_W     = $clog2(QUO_W);
    localparam logic [WEIGHT_W-1:0] ONE_W = WEIGHT_W'(1) << FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTS    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_OK   = 3'd7;

    typedef struct packed {
        logic [2:0][POS_W-1:0]      origin;
        logic [2:0][POS_W-1:0]      spacing;
        logic [2:0][COUNT_BITS-1:0] counts;
        logic                       data_ok;
    } t_cfg;

    typedef struct packed {
        logic                       failed;
        logic [2:0][COUNT_BITS-1:0] lo;
        logic [2:0][COUNT_BITS-1:0] hi;
        logic [2:0][FRAC_BITS-1:0]  frac;
    } t_item;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_PUSH
    } t_front_state;

endpackage

>>> hw/rtl/pgtl_front.sv
// Front end: accepts a query, divides each axis by its spacing and forms the corners.
module pgtl_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [pgtl_pkg::POS_W-1:0]    i_pos_x,
    input  logic [pgtl_pkg::POS_W-1:0]    i_pos_y,
    input  logic [pgtl_pkg::POS_W-1:0]    i_pos_z,
    input  pgtl_pkg::t_cfg                i_cfg,
    output logic                          o_push,
    output pgtl_pkg::t_item               o_item,
    input  logic                          i_full
);

    pgtl_pkg::t_front_state r_state, n_state;
    logic [pgtl_pkg::STEP_W-1:0]          r_step, n_step;
    logic                                 r_fail, n_fail;
    logic [2:0][pgtl_pkg::QUO_W-1:0]      r_quo, n_quo;
    logic [2:0][pgtl_pkg::UD_W-1:0]       r_rem, n_rem;
    logic [2:0][pgtl_pkg::POS_W-1:0]      pos;
    logic [2:0][pgtl_pkg::POS_W-1:0]      spc;
    logic [2:0][pgtl_pkg::DIFF_W-1:0]     diff;
    logic [2:0][pgtl_pkg::UD_W-1:0]       ud;
    logic [2:0][pgtl_pkg::UD_W-1:0]       shifted;
    logic [2:0][pgtl_pkg::COUNT_BITS-1:0] maxi;
    logic [2:0][pgtl_pkg::UD_W-1:0]       ipart;
    logic [2:0][pgtl_pkg::COUNT_BITS-1:0] lo;

    assign pos = {i_pos_z, i_pos_y, i_pos_x};

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            spc[a] = (i_cfg.spacing[a] == '0) ? pgtl_pkg::POS_W'(1) : i_cfg.spacing[a];
            diff[a] = {{2{pos[a][pgtl_pkg::POS_W-1]}}, pos[a]}
                    - {{2{i_cfg.origin[a][pgtl_pkg::POS_W-1]}}, i_cfg.origin[a]};
            ud[a] = (diff[a][pgtl_pkg::DIFF_W-1] || diff[a] == '0)
                  ? '0 : diff[a][pgtl_pkg::UD_W-1:0];
            shifted[a] = {r_rem[a][pgtl_pkg::POS_W-1:0],
                          r_quo[a][pgtl_pkg::QUO_W-1]};
            maxi[a] = (i_cfg.counts[a] == '0) ? '0 : i_cfg.counts[a] - 1'b1;
            ipart[a] = r_quo[a][pgtl_pkg::QUO_W-1:pgtl_pkg::FRAC_BITS];
            lo[a] = (ipart[a] > pgtl_pkg::UD_W'(maxi[a]))
                  ? maxi[a] : ipart[a][pgtl_pkg::COUNT_BITS-1:0];
            o_item.lo[a] = lo[a];
            o_item.hi[a] = (lo[a] >= maxi[a]) ? maxi[a] : lo[a] + 1'b1;
            o_item.frac[a] = r_quo[a][pgtl_pkg::FRAC_BITS-1:0];
        end
        o_item.failed = r_fail;
        if (r_fail) begin
            o_item.lo   = '0;
            o_item.hi   = '0;
            o_item.frac = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_fail  = r_fail;
        n_quo   = r_quo;
        n_rem   = r_rem;
        o_push  = 1'b0;
        case (r_state)
            pgtl_pkg::FS_IDLE: begin
                if (i_start) begin
                    n_fail = !i_cfg.data_ok;
                    n_step = '0;
                    for (int a = 0; a < 3; a++) begin
                        n_quo[a] = {ud[a], {pgtl_pkg::FRAC_BITS{1'b0}}};
                        n_rem[a] = '0;
                    end
                    n_state = i_cfg.data_ok ? pgtl_pkg::FS_DIV : pgtl_pkg::FS_PUSH;
                end
            end
            pgtl_pkg::FS_DIV: begin
                // Restoring division, one quotient bit per cycle on all three axes.
                for (int a = 0; a < 3; a++) begin
                    if (shifted[a] >= pgtl_pkg::UD_W'(spc[a])) begin
                        n_rem[a] = shifted[a] - pgtl_pkg::UD_W'(spc[a]);
                        n_quo[a] = {r_quo[a][pgtl_pkg::QUO_W-2:0], 1'b1};
                    end else begin
                        n_rem[a] = shifted[a];
                        n_quo[a] = {r_quo[a][pgtl_pkg::QUO_W-2:0], 1'b0};
                    end
                end
                n_step = r_step + 1'b1;
                if (r_step == pgtl_pkg::STEP_W'(pgtl_pkg::QUO_W - 1)) begin
                    n_state = pgtl_pkg::FS_PUSH;
                end
            end
            pgtl_pkg::FS_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = pgtl_pkg::FS_IDLE;
                end
            end
            default: n_state = pgtl_pkg::FS_IDLE;
        endcase
    end

    assign o_busy = (r_state != pgtl_pkg::FS_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pgtl_pkg::FS_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_step <= n_step;
        r_fail <= n_fail;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
    end

endmodule

>>> hw/rtl/pgtl_queue.sv
// Two-entry queue between the front end and the result sequencer.
module pgtl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pgtl_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output pgtl_pkg::t_item o_item,
    output logic            o_empty
);

    pgtl_pkg::t_item r_mem [2];
    logic            r_wr, r_rd;
    logic [1:0]      r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) r_mem[r_wr] <= i_item;
    end

endmodule

>>> hw/rtl/pgtl_back.sv
// Result sequencer: walks the eight corners, forming index and weight for each.
module pgtl_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [2:0][pgtl_pkg::COUNT_BITS-1:0] i_counts,
    input  logic                          i_empty,
    input  pgtl_pkg::t_item               i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic [2:0]                    o_corner,
    output logic [pgtl_pkg::IDX_W-1:0]    o_probe_index,
    output logic [pgtl_pkg::WEIGHT_W-1:0] o_weight,
    output logic                          o_failed,
    output logic                          o_last
);

    localparam int CB = pgtl_pkg::COUNT_BITS;
    localparam int FB = pgtl_pkg::FRAC_BITS;
    localparam int WW = pgtl_pkg::WEIGHT_W;
    localparam int SUM_W = 3 * CB + 2;

    logic                 r_active;
    logic                 r_phase;
    logic [2:0]           r_corner;
    pgtl_pkg::t_item      r_item;
    logic [WW-1:0]        r_pxy;
    logic [3*CB-1:0]      r_zi;
    logic [2*CB-1:0]      r_yi;
    logic [2*CB-1:0]      r_xy;
    logic [CB-1:0]        cx, cy;
    logic [2:0][CB-1:0]   sel;
    logic [2:0][WW-1:0]   w;
    logic [2*WW-1:0]      prod_xy, prod_z;
    logic [SUM_W-1:0]     idx_sum;

    assign cx = (i_counts[0] == '0) ? CB'(1) : i_counts[0];
    assign cy = (i_counts[1] == '0) ? CB'(1) : i_counts[1];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            sel[a] = r_corner[a] ? r_item.hi[a] : r_item.lo[a];
            w[a] = r_corner[a] ? {1'b0, r_item.frac[a]}
                               : pgtl_pkg::ONE_W - {1'b0, r_item.frac[a]};
        end
        prod_xy = w[0] * w[1];
        prod_z  = r_pxy * w[2];
        idx_sum = SUM_W'(r_zi) + SUM_W'(r_yi) + SUM_W'(sel[0]);
    end

    assign o_pop = !r_active && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (o_pop) begin
                r_active <= 1'b1;
            end else if (r_active && (r_item.failed || (r_phase && r_corner == 3'd7))) begin
                r_active <= 1'b0;
                o_valid  <= 1'b1;
            end else if (r_active && r_phase) begin
                o_valid <= 1'b1;
            end
        end
        r_xy <= cx * cy;
        if (o_pop) begin
            r_item   <= i_item;
            r_phase  <= 1'b0;
            r_corner <= '0;
        end else if (r_active) begin
            if (r_item.failed) begin
                o_corner      <= '0;
                o_probe_index <= '0;
                o_weight      <= '0;
                o_failed      <= 1'b1;
                o_last        <= 1'b1;
            end else if (!r_phase) begin
                r_pxy   <= prod_xy[FB+WW-1:FB];
                r_zi    <= sel[2] * r_xy;
                r_yi    <= sel[1] * cx;
                r_phase <= 1'b1;
            end else begin
                o_corner      <= r_corner;
                o_probe_index <= pgtl_pkg::IDX_W'(idx_sum);
                o_weight      <= prod_z[FB+WW-1:FB];
                o_failed      <= 1'b0;
                o_last        <= (r_corner == 3'd7);
                r_corner      <= r_corner + 1'b1;
                r_phase       <= 1'b0;
            end
        end
    end

endmodule

>>> hw/rtl/probe_grid_trilinear_lookup_core.sv
// Top level of the probe grid trilinear lookup: configuration registers and the three parts.
// A query is taken when i_start is high and o_busy low; o_busy then stays high while the
// front end works on it and until it hands the item on, waiting while the queue is full.
// The result strobes follow, one for each of the eight corners in turn, or a single failure
// strobe for a query made without probe data. The receiver cannot stall.
// Synchronous active-low reset clears control state and loads the register reset values.
module probe_grid_trilinear_lookup_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [pgtl_pkg::POS_W-1:0]         i_pos_x,
    input  logic [pgtl_pkg::POS_W-1:0]         i_pos_y,
    input  logic [pgtl_pkg::POS_W-1:0]         i_pos_z,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pgtl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pgtl_pkg::POS_W-1:0]         i_cfg_data,
    output logic                               o_valid,
    output logic [2:0]                         o_corner,
    output logic [pgtl_pkg::IDX_W-1:0]         o_probe_index,
    output logic [pgtl_pkg::WEIGHT_W-1:0]      o_weight,
    output logic                               o_failed,
    output logic                               o_last
);

    pgtl_pkg::t_cfg  r_cfg;
    pgtl_pkg::t_item front_item, queue_item;
    logic            push, pop, full, empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin  <= '0;
            r_cfg.spacing <= {3{pgtl_pkg::POS_W'(65536)}};
            r_cfg.counts  <= {3{pgtl_pkg::COUNT_BITS'(1)}};
            r_cfg.data_ok <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pgtl_pkg::REG_ORIGIN_X:  r_cfg.origin[0]  <= i_cfg_data;
                pgtl_pkg::REG_ORIGIN_Y:  r_cfg.origin[1]  <= i_cfg_data;
                pgtl_pkg::REG_ORIGIN_Z:  r_cfg.origin[2]  <= i_cfg_data;
                pgtl_pkg::REG_SPACING_X: r_cfg.spacing[0] <= i_cfg_data;
                pgtl_pkg::REG_SPACING_Y: r_cfg.spacing[1] <= i_cfg_data;
                pgtl_pkg::REG_SPACING_Z: r_cfg.spacing[2] <= i_cfg_data;
                pgtl_pkg::REG_COUNTS:
                    r_cfg.counts <= i_cfg_data[3*pgtl_pkg::COUNT_BITS-1:0];
                pgtl_pkg::REG_DATA_OK:   r_cfg.data_ok    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    pgtl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .i_pos_z (i_pos_z),
        .i_cfg   (r_cfg),
        .o_push  (push),
        .o_item  (front_item),
        .i_full  (full)
    );

    pgtl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_empty (empty)
    );

    pgtl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_counts      (r_cfg.counts),
        .i_empty       (empty),
        .i_item        (queue_item),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_corner      (o_corner),
        .o_probe_index (o_probe_index),
        .o_weight      (o_weight),
        .o_failed      (o_failed),
        .o_last        (o_last)
    );

endmodule

>>> tb/sv/tb_top.sv
// Testbench for the probe grid trilinear lookup core: random queries checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
    import pgtl_pkg::*;

    typedef struct {
        logic [2:0]          corner;
        logic [IDX_W-1:0]    probe_index;
        logic [WEIGHT_W-1:0] weight;
        logic                failed;
        logic                last;
    } t_probe_weight;

    class probe_weight_board;
        t_probe_weight pending[$];
        int            errors;
        logic signed [POS_W-1:0] org[3];
        logic [POS_W-1:0]        spc[3];
        logic [3*COUNT_BITS-1:0] counts;
        logic                    data_ok;

        function void reset_regs();
            for (int a = 0; a < 3; a++) begin
                org[a] = '0;
                spc[a] = 32'd65536;
            end
            counts  = 24'h010101;
            data_ok = 1'b0;
            errors  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] data);
            case (idx)
                REG_ORIGIN_X:  org[0] = data;
                REG_ORIGIN_Y:  org[1] = data;
                REG_ORIGIN_Z:  org[2] = data;
                REG_SPACING_X: spc[0] = data;
                REG_SPACING_Y: spc[1] = data;
                REG_SPACING_Z: spc[2] = data;
                REG_COUNTS:    counts = data[3*COUNT_BITS-1:0];
                REG_DATA_OK:   data_ok = data[0];
                default: ;
            endcase
        endfunction

        // Notes an accepted query and queues the corner weights it should give.
        function void note_query(logic [POS_W-1:0] pos[3]);
            t_probe_weight r;
            longint signed d;
            longint unsigned cnt[3], lo[3], hi[3], fr[3], sp, ip, w, wa[3], ca[3];
            if (!data_ok) begin
                r = '{3'd0, '0, '0, 1'b1, 1'b1};
                pending.push_back(r);
                return;
            end
            for (int a = 0; a < 3; a++) begin
                cnt[a] = counts[a*COUNT_BITS +: COUNT_BITS];
                if (cnt[a] == 0) cnt[a] = 1;
                sp = (spc[a] == 0) ? 1 : spc[a];
                d  = longint'($signed(pos[a])) - longint'(org[a]);
                ip = 0;
                fr[a] = 0;
                if (d > 0) begin
                    ip    = longint'(d) / sp;
                    fr[a] = ((longint'(d) % sp) << FRAC_BITS) / sp;
                end
                if (ip > cnt[a] - 1) ip = cnt[a] - 1;
                lo[a] = ip;
                hi[a] = (ip + 1 > cnt[a] - 1) ? cnt[a] - 1 : ip + 1;
            end
            for (int k = 0; k < 8; k++) begin
                for (int a = 0; a < 3; a++) begin
                    ca[a] = k[a] ? hi[a] : lo[a];
                    wa[a] = k[a] ? fr[a] : (64'd1 << FRAC_BITS) - fr[a];
                end
                w = (((wa[0] * wa[1]) >> FRAC_BITS) * wa[2]) >> FRAC_BITS;
                r.corner      = k[2:0];
                r.probe_index = IDX_W'(ca[2] * cnt[0] * cnt[1] + ca[1] * cnt[0] + ca[0]);
                r.weight      = WEIGHT_W'(w);
                r.failed      = 1'b0;
                r.last        = (k == 7);
                pending.push_back(r);
            end
        endfunction

        function void check_result(t_probe_weight got);
            t_probe_weight exp;
            if (pending.size() == 0) begin
                $error("unexpected result, corner %0d", got.corner);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.corner !== exp.corner) begin
                $error("corner: expected %0d, got %0d", exp.corner, got.corner);
                errors++;
            end
            if (got.probe_index !== exp.probe_index) begin
                $error("probe_index: expected %0d, got %0d", exp.probe_index, got.probe_index);
                errors++;
            end
            if (got.weight !== exp.weight) begin
                $error("weight: expected %0d, got %0d", exp.weight, got.weight);
                errors++;
            end
            if (got.failed !== exp.failed) begin
                $error("failed: expected %0d, got %0d", exp.failed, got.failed);
                errors++;
            end
            if (got.last !== exp.last) begin
                $error("last: expected %0d, got %0d", exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic [POS_W-1:0]     i_pos_x, i_pos_y, i_pos_z;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [POS_W-1:0]     i_cfg_data;
    logic                 o_valid;
    logic [2:0]           o_corner;
    logic [IDX_W-1:0]     o_probe_index;
    logic [WEIGHT_W-1:0]  o_weight;
    logic                 o_failed;
    logic                 o_last;

    probe_grid_trilinear_lookup_core u_top (.*);

    probe_weight_board board = new();
    int unsigned       cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The limit lies well above the slowest run, each query with its random idle gap before it.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            board.check_result('{o_corner, o_probe_index, o_weight, o_failed, o_last});
    end

    task automatic idle_cycles(int n);
        repeat (n) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_query(logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [POS_W-1:0] z);
        logic [POS_W-1:0] p[3];
        p = '{x, y, z};
        idle_cycles($urandom_range(0, 1) ? 0 : $urandom_range(0, 19));
        @(negedge i_clk);
        i_start <= 1'b1;
        i_pos_x <= x;
        i_pos_y <= y;
        i_pos_z <= z;
        do @(posedge i_clk); while (o_busy);
        board.note_query(p);
        @(negedge i_clk);
        i_start <= 1'b0;
    endtask

    // Waits for all results, then for the block to settle before any register write.
    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        idle_cycles(80);
    endtask

    function automatic logic [POS_W-1:0] rand_pos(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 32'h000F_FFFF);
            default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
        endcase
    endfunction

    task automatic random_setting();
        write_reg(REG_ORIGIN_X, $urandom_range(0, 3) == 0 ? $urandom() : 32'(-$urandom_range(0, 65536*4)));
        write_reg(REG_ORIGIN_Y, $urandom_range(0, 3) == 0 ? $urandom() : 32'(-$urandom_range(0, 65536*4)));
        write_reg(REG_ORIGIN_Z, $urandom_range(0, 3) == 0 ? $urandom() : 32'(-$urandom_range(0, 65536*4)));
        write_reg(REG_SPACING_X, $urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(0, 32'h0004_0000));
        write_reg(REG_SPACING_Y, $urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(0, 32'h0004_0000));
        write_reg(REG_SPACING_Z, $urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(1, 32'h0004_0000));
        write_reg(REG_COUNTS, $urandom_range(0, 32'hFF_FFFF));
        write_reg(REG_DATA_OK, 32'($urandom_range(0, 7) != 0));
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_pos_x     = '0;
        i_pos_y     = '0;
        i_pos_z     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_ORIGIN_X;
        i_cfg_data  = '0;
        cycle_count = 0;
        board.reset_regs();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // No probe data yet: a single failure result.
        send_query(32'h0001_8000, 32'h0, 32'h0);
        drain();
        write_reg(REG_DATA_OK, 32'd1);
        write_reg(REG_COUNTS, 32'h0004_0404);
        send_query(32'h0001_8000, 32'h0002_4000, 32'h0000_C000);
        send_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_query(32'hFFFF_FFFF, 32'h0, 32'h0003_0000);
        drain();
        // Extreme registers: zero spacing and counts, full counts, extreme origins.
        write_reg(REG_SPACING_X, 32'h0);
        write_reg(REG_SPACING_Y, 32'hFFFF_FFFF);
        write_reg(REG_SPACING_Z, 32'h1);
        write_reg(REG_COUNTS, 32'h0000_FF00);
        write_reg(REG_ORIGIN_X, 32'h8000_0000);
        write_reg(REG_ORIGIN_Y, 32'h7FFF_FFFF);
        write_reg(REG_ORIGIN_Z, 32'h0);
        send_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0005);
        send_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        send_query(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0080);
        drain();
        write_reg(REG_COUNTS, 32'h00FF_FFFF);
        write_reg(REG_ORIGIN_X, 32'h7FFF_FFFF);
        write_reg(REG_ORIGIN_Y, 32'h8000_0000);
        write_reg(REG_SPACING_X, 32'h0000_0100);
        send_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h00FF_FFFF);
        send_query(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);

        for (int phase = 0; phase < 10; phase++) begin
            drain();
            random_setting();
            for (int n = 0; n < 25; n++)
                send_query(rand_pos($urandom_range(0, 2)), rand_pos($urandom_range(0, 2)),
                           rand_pos($urandom_range(0, 2)));
        end

        drain();
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/pgtl_pkg.sv
hw/rtl/pgtl_front.sv
hw/rtl/pgtl_queue.sv
hw/rtl/pgtl_back.sv
hw/rtl/probe_grid_trilinear_lookup_core.sv
tb/sv/tb_top.sv
